// File: design/s2c_pkg.sv
`default_nettype none

package s2c_pkg;

	localparam int CORDIC_STAGES = 30;
	localparam int STAGE_IDX_W = $clog2(CORDIC_STAGES);
	localparam int ROT_W = 33;

	localparam logic [24:0] DEG_90 = 25'd5898240;
	localparam logic [24:0] DEG_180 = 25'd11796480;
	localparam logic [24:0] DEG_270 = 25'd17694720;
	localparam logic [24:0] DEG_360 = 25'd23592960;

	localparam logic [63:0] DEG2RAD_Q40 = 64'd19190098069;
	localparam logic [16:0] D2R_HI = 17'(DEG2RAD_Q40 >> 18);
	localparam logic [17:0] D2R_LO = DEG2RAD_Q40[17:0];

	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;

	localparam logic [29:0] ATAN_TAB [10] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149
	};

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
	} rot_t;

	typedef struct packed {
		quad_t ra_quad;
		quad_t dec_quad;
		logic [31:0] dist_q16;
		logic last;
	} side_t;

	typedef struct packed {
		logic signed [47:0] z;
		logic signed [47:0] y;
		logic signed [47:0] x;
		logic last;
	} res_t;

	function automatic logic signed [ROT_W-1:0] atan_q30(input logic [STAGE_IDX_W-1:0] i);
		logic signed [ROT_W-1:0] a;
		a = '0;
		if (int'(i) < 10) begin
			a = ROT_W'(ATAN_TAB[i[3:0]]);
		end else if (int'(i) <= 30) begin
			a = ROT_W'(64'd1 << (30 - int'(i)));
		end
		return a;
	endfunction

endpackage

`default_nettype wire

// File: design/spherical_to_cartesian_top.sv
// Path from an accepted input word to m_axis_tvalid, in order:
// 4 angle prep stages, one CORDIC cell per stage, 5 scale stages, output register.
// Throughput: one word per cycle while the input is not stalled, set by the fully pipelined cell chain and multipliers.
// Input stalls only when the output register and skid register are both full.
// Reset (arst_n low, asynchronous): pipeline and output emptied, scale_by_distance = 0.
`default_nettype none

module spherical_to_cartesian_top import s2c_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [87:0]  s_axis_tdata, // ra_angle, dec_angle, distance
	input  wire logic         s_axis_tlast, // last_in
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [143:0]      m_axis_tdata, // x_coord, y_coord, z_coord
	output logic              m_axis_tlast, // last_out
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_data
);

	logic  en;
	logic  scale_q;
	logic  vld_ch [CORDIC_STAGES+1];
	rot_t  ra_ch [CORDIC_STAGES+1];
	rot_t  dec_ch [CORDIC_STAGES+1];
	side_t side_ch [CORDIC_STAGES+1];
	logic  res_vld;
	res_t  res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	s2c_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_axis_tvalid),
		.ra_angle  (s_axis_tdata[24:0]),
		.dec_angle (s_axis_tdata[48:25]),
		.distance  (s_axis_tdata[80:49]),
		.last_in   (s_axis_tlast),
		.out_vld   (vld_ch[0]),
		.ra_rot    (ra_ch[0]),
		.dec_rot   (dec_ch[0]),
		.side      (side_ch[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		s2c_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.idx      (STAGE_IDX_W'(g)),
			.in_vld   (vld_ch[g]),
			.ra_in    (ra_ch[g]),
			.dec_in   (dec_ch[g]),
			.side_in  (side_ch[g]),
			.out_vld  (vld_ch[g+1]),
			.ra_out   (ra_ch[g+1]),
			.dec_out  (dec_ch[g+1]),
			.side_out (side_ch[g+1])
		);
	end

	s2c_scale u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.scale_by_distance (scale_q),
		.in_vld            (vld_ch[CORDIC_STAGES]),
		.ra_rot            (ra_ch[CORDIC_STAGES]),
		.dec_rot           (dec_ch[CORDIC_STAGES]),
		.side              (side_ch[CORDIC_STAGES]),
		.out_vld           (res_vld),
		.res               (res)
	);

	s2c_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (res_vld),
		.in_res        (res),
		.en            (en),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: design/s2c_prep.sv
`default_nettype none

module s2c_prep import s2c_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire logic [24:0]        ra_angle,
	input  wire logic signed [23:0] dec_angle,
	input  wire logic [31:0]        distance,
	input  wire logic               last_in,
	output logic                    out_vld,
	output rot_t                    ra_rot,
	output rot_t                    dec_rot,
	output side_t                   side
);

	logic [24:0] ang_c [2];
	logic [24:0] dec_ext;
	logic [24:0] ang_s1 [2];
	logic [31:0] dist_s1;
	logic        last_s1;
	logic        vld_s1;

	quad_t       quad_c [2];
	logic [22:0] rem_c [2];
	quad_t       quad_s2 [2];
	logic [22:0] rem_s2 [2];
	logic [31:0] dist_s2;
	logic        last_s2;
	logic        vld_s2;

	logic [39:0] pp_hi_s3 [2];
	logic [40:0] pp_lo_s3 [2];
	quad_t       quad_s3 [2];
	logic [31:0] dist_s3;
	logic        last_s3;
	logic        vld_s3;

	logic [57:0] sum_c [2];
	logic [30:0] theta_s4 [2];
	quad_t       quad_s4 [2];
	logic [31:0] dist_s4;
	logic        last_s4;
	logic        vld_s4;

	// reduce both angles into [0, 360)
	always_comb begin
		dec_ext = {dec_angle[23], dec_angle};
		ang_c[0] = (ra_angle >= DEG_360) ? ra_angle - DEG_360 : ra_angle;
		ang_c[1] = dec_angle[23] ? dec_ext + DEG_360 : dec_ext;
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			if (ang_s1[k] >= DEG_270) begin
				quad_c[k] = QUAD_3;
				rem_c[k] = 23'(ang_s1[k] - DEG_270);
			end else if (ang_s1[k] >= DEG_180) begin
				quad_c[k] = QUAD_2;
				rem_c[k] = 23'(ang_s1[k] - DEG_180);
			end else if (ang_s1[k] >= DEG_90) begin
				quad_c[k] = QUAD_1;
				rem_c[k] = 23'(ang_s1[k] - DEG_90);
			end else begin
				quad_c[k] = QUAD_0;
				rem_c[k] = ang_s1[k][22:0];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			sum_c[k] = {pp_hi_s3[k], 18'd0} + 58'(pp_lo_s3[k]) + 58'd33554432;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				ang_s1[k]   <= ang_c[k];
				quad_s2[k]  <= quad_c[k];
				rem_s2[k]   <= rem_c[k];
				pp_hi_s3[k] <= 40'(rem_s2[k]) * 40'(D2R_HI);
				pp_lo_s3[k] <= 41'(rem_s2[k]) * 41'(D2R_LO);
				quad_s3[k]  <= quad_s2[k];
				theta_s4[k] <= sum_c[k][56:26];
				quad_s4[k]  <= quad_s3[k];
			end
			dist_s1 <= distance;
			last_s1 <= last_in;
			dist_s2 <= dist_s1;
			last_s2 <= last_s1;
			dist_s3 <= dist_s2;
			last_s3 <= last_s2;
			dist_s4 <= dist_s3;
			last_s4 <= last_s3;
		end
	end

	assign out_vld = vld_s4;

	always_comb begin
		ra_rot.x = CORDIC_GAIN;
		ra_rot.y = '0;
		ra_rot.z = ROT_W'(theta_s4[0]);
		dec_rot.x = CORDIC_GAIN;
		dec_rot.y = '0;
		dec_rot.z = ROT_W'(theta_s4[1]);
		side.ra_quad = quad_s4[0];
		side.dec_quad = quad_s4[1];
		side.dist_q16 = dist_s4;
		side.last = last_s4;
	end

endmodule

`default_nettype wire

// File: design/s2c_cell.sv
`default_nettype none

module s2c_cell import s2c_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic [STAGE_IDX_W-1:0] idx,
	input  wire logic                   in_vld,
	input  wire rot_t                   ra_in,
	input  wire rot_t                   dec_in,
	input  wire side_t                  side_in,
	output logic                        out_vld,
	output rot_t                        ra_out,
	output rot_t                        dec_out,
	output side_t                       side_out
);

	logic signed [ROT_W-1:0] ang;
	logic                    vld_q;
	rot_t                    ra_q;
	rot_t                    dec_q;
	side_t                   side_q;

	function automatic rot_t rotate(input rot_t v, input logic [STAGE_IDX_W-1:0] i,
			input logic signed [ROT_W-1:0] a);
		rot_t r;
		logic signed [ROT_W-1:0] vx;
		logic signed [ROT_W-1:0] vy;
		logic signed [ROT_W-1:0] vz;
		logic signed [ROT_W-1:0] dx;
		logic signed [ROT_W-1:0] dy;
		vx = v.x;
		vy = v.y;
		vz = v.z;
		dx = vy >>> i;
		dy = vx >>> i;
		if (!vz[ROT_W-1]) begin
			r.x = vx - dx;
			r.y = vy + dy;
			r.z = vz - a;
		end else begin
			r.x = vx + dx;
			r.y = vy - dy;
			r.z = vz + a;
		end
		return r;
	endfunction

	assign ang = atan_q30(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_q   <= rotate(ra_in, idx, ang);
			dec_q  <= rotate(dec_in, idx, ang);
			side_q <= side_in;
		end
	end

	assign out_vld  = vld_q;
	assign ra_out   = ra_q;
	assign dec_out  = dec_q;
	assign side_out = side_q;

endmodule

`default_nettype wire

// File: design/s2c_scale.sv
`default_nettype none

module s2c_scale import s2c_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  scale_by_distance,
	input  wire logic  in_vld,
	input  wire rot_t  ra_rot,
	input  wire rot_t  dec_rot,
	input  wire side_t side,
	output logic       out_vld,
	output res_t       res
);

	typedef struct packed {
		logic [30:0] cmag;
		logic        cneg;
		logic [30:0] smag;
		logic        sneg;
	} trig_t;

	function automatic logic [30:0] clamp_unit(input logic signed [ROT_W-1:0] v);
		logic [30:0] r;
		if (v[ROT_W-1]) begin
			r = '0;
		end else if (v > signed'(ROT_W'(ONE_Q30))) begin
			r = ONE_Q30;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	function automatic trig_t map_quad(input quad_t q, input logic [30:0] c,
			input logic [30:0] s);
		trig_t t;
		case (q)
			QUAD_0: begin
				t = '{cmag: c, cneg: 1'b0, smag: s, sneg: 1'b0};
			end
			QUAD_1: begin
				t = '{cmag: s, cneg: 1'b1, smag: c, sneg: 1'b0};
			end
			QUAD_2: begin
				t = '{cmag: c, cneg: 1'b1, smag: s, sneg: 1'b1};
			end
			QUAD_3: begin
				t = '{cmag: s, cneg: 1'b0, smag: c, sneg: 1'b1};
			end
			default: begin
				t = '{cmag: c, cneg: 1'b0, smag: s, sneg: 1'b0};
			end
		endcase
		return t;
	endfunction

	trig_t       rt_s1;
	trig_t       dt_s1;
	logic [31:0] dist_s1;
	logic        last_s1;

	logic [61:0] px_s2;
	logic [61:0] py_s2;
	logic [30:0] zmag_s2;
	logic [2:0]  neg_s2;
	logic [31:0] dist_s2;
	logic        last_s2;

	logic [30:0] ux_s3;
	logic [30:0] uy_s3;
	logic [30:0] uz_s3;
	logic [2:0]  neg_s3;
	logic [31:0] dist_s3;
	logic        last_s3;

	logic [62:0] dx_s4;
	logic [62:0] dy_s4;
	logic [62:0] dz_s4;
	logic [30:0] ux_s4;
	logic [30:0] uy_s4;
	logic [30:0] uz_s4;
	logic [2:0]  neg_s4;
	logic        last_s4;

	logic [62:0] dx_r;
	logic [62:0] dy_r;
	logic [62:0] dz_r;
	logic [47:0] mx;
	logic [47:0] my;
	logic [47:0] mz;
	res_t        res_c;
	res_t        res_s5;
	logic [4:0]  vld_q;

	always_comb begin
		dx_r = dx_s4 + 63'd32768;
		dy_r = dy_s4 + 63'd32768;
		dz_r = dz_s4 + 63'd32768;
		mx = scale_by_distance ? 48'(dx_r[62:16]) : 48'(ux_s4);
		my = scale_by_distance ? 48'(dy_r[62:16]) : 48'(uy_s4);
		mz = scale_by_distance ? 48'(dz_r[62:16]) : 48'(uz_s4);
		res_c.x = neg_s4[0] ? -signed'(mx) : signed'(mx);
		res_c.y = neg_s4[1] ? -signed'(my) : signed'(my);
		res_c.z = neg_s4[2] ? -signed'(mz) : signed'(mz);
		res_c.last = last_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s1   <= map_quad(side.ra_quad, clamp_unit(ra_rot.x), clamp_unit(ra_rot.y));
			dt_s1   <= map_quad(side.dec_quad, clamp_unit(dec_rot.x), clamp_unit(dec_rot.y));
			dist_s1 <= side.dist_q16;
			last_s1 <= side.last;

			px_s2   <= 62'(dt_s1.cmag) * 62'(rt_s1.cmag);
			py_s2   <= 62'(dt_s1.cmag) * 62'(rt_s1.smag);
			zmag_s2 <= dt_s1.smag;
			neg_s2  <= {dt_s1.sneg, dt_s1.cneg ^ rt_s1.sneg, dt_s1.cneg ^ rt_s1.cneg};
			dist_s2 <= dist_s1;
			last_s2 <= last_s1;

			ux_s3   <= 31'((px_s2 + 62'd536870912) >> 30);
			uy_s3   <= 31'((py_s2 + 62'd536870912) >> 30);
			uz_s3   <= zmag_s2;
			neg_s3  <= neg_s2;
			dist_s3 <= dist_s2;
			last_s3 <= last_s2;

			dx_s4   <= 63'(ux_s3) * 63'(dist_s3);
			dy_s4   <= 63'(uy_s3) * 63'(dist_s3);
			dz_s4   <= 63'(uz_s3) * 63'(dist_s3);
			ux_s4   <= ux_s3;
			uy_s4   <= uy_s3;
			uz_s4   <= uz_s3;
			neg_s4  <= neg_s3;
			last_s4 <= last_s3;

			res_s5  <= res_c;
		end
	end

	assign out_vld = vld_q[4];
	assign res = res_s5;

endmodule

`default_nettype wire

// File: design/s2c_outbuf.sv
`default_nettype none

module s2c_outbuf import s2c_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_vld,
	input  wire res_t           in_res,
	output logic                en,
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	output logic [143:0]        m_axis_tdata, // x_coord, y_coord, z_coord
	output logic                m_axis_tlast
);

	res_t out_q;
	res_t skid_q;
	logic out_vld_q;
	logic skid_vld_q;
	logic from_skid;
	logic load_out;
	logic load_skid;

	assign en        = !skid_vld_q;
	assign from_skid = skid_vld_q && m_axis_tready;
	assign load_out  = !skid_vld_q && in_vld && (!out_vld_q || m_axis_tready);
	assign load_skid = !skid_vld_q && in_vld && out_vld_q && !m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (from_skid) begin
				skid_vld_q <= 1'b0;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!skid_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (from_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= in_res;
		end
		if (load_skid) begin
			skid_q <= in_res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.z, out_q.y, out_q.x};
	assign m_axis_tlast  = out_q.last;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word held with empty output register");
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_vld && en && out_vld_q && !m_axis_tready) |=> skid_vld_q)
		else $error("pipeline word dropped on output stall");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && m_axis_tready) |=> (!skid_vld_q && out_vld_q))
		else $error("skid word not moved to output register");
`endif

endmodule

`default_nettype wire
